FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the hue key pipeline to check it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk and switched off while aresetn is low.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on aclk and switched off while aresetn is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/hcka_pkg.sv
// Types and constants of the hue chroma key pipeline.
`timescale 1ns / 1ps

package hcka_pkg;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 9;
    localparam int DIFF_W    = CH_W + 1;
    localparam int PROD_W    = 17;
    localparam int NUM_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = HUE_W;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 1'b1;

    localparam logic [HUE_W-1:0] HUE_LOW_RST  = 9'd131;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST = 9'd145;

    localparam logic [CH_W-1:0] ALPHA_KEYED  = 8'd0;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

    // Which channel holds the maximum; red wins ties, then green.
    typedef enum logic [1:0] {
        SEC_RED   = 2'b00,
        SEC_GREEN = 2'b01,
        SEC_BLUE  = 2'b10
    } sector_t;

    typedef struct packed {
        sector_t                   sector;
        logic [CH_W-1:0]           delta;
        logic signed [DIFF_W-1:0]  diff;
    } sector_info_t;

endpackage

FILE: hdl/hue_chroma_key_alpha_unit.sv
// Top level of the hue chroma key: four-stage pipeline from RGB pixel to keyed RGBA.
//
//  Channel | Direction | Ports                                 | Contents
//  s_      | in        | s_tvalid, s_tready, s_tdata[23:0]     | red, green, blue
//  m_      | out       | m_tvalid, m_tready, m_tdata[31:0]     | red, green, blue, alpha
//  cfg_    | in        | cfg_wr_en, cfg_index, cfg_wdata[8:0]  | hue_low, hue_high
//
// One pixel is taken every cycle while the output is not stalled; each result passes through
// the four register stages (sector, products, wrap, compare).
// Reset (aresetn low at a clock edge) empties the pipeline and loads the bounds 131 and 145.
// Each stage holds its item only while the stage after it is full and stalled, so bubbles
// are squeezed out and s_tready falls only when all four stages are occupied.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hue_chroma_key_alpha_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hcka_pkg::S_DATA_W-1:0]      s_tdata,   // red, green, blue
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hcka_pkg::M_DATA_W-1:0]      m_tdata,   // red, green, blue, alpha
    input  logic                               cfg_wr_en,
    input  logic [hcka_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hcka_pkg::CFG_W-1:0]         cfg_wdata
);
    import hcka_pkg::*;

    logic [HUE_W-1:0] hue_low_reg;
    logic [HUE_W-1:0] hue_high_reg;

    // Stage enables, from the output back to the input.
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg;

    sector_info_t     sec_info;
    sector_info_t     s1_info_reg;
    logic [S_DATA_W-1:0] s1_rgb_reg;
    logic [S_DATA_W-1:0] s2_rgb_reg;
    logic [S_DATA_W-1:0] s3_rgb_reg;

    logic [PROD_W-1:0]       d17;
    logic [PROD_W-1:0]       base_next;
    logic signed [NUM_W-1:0] diff_ext;
    logic signed [NUM_W-1:0] diff60;
    logic signed [NUM_W-1:0] num_next;
    logic [PROD_W-1:0]       d360_next;
    logic [PROD_W-1:0]       lowd_next;
    logic [PROD_W-1:0]       highd_next;

    logic signed [NUM_W-1:0] s2_num_reg;
    logic [PROD_W-1:0]       s2_d360_reg;
    logic [PROD_W-1:0]       s2_lowd_reg;
    logic [PROD_W-1:0]       s2_highd_reg;

    logic signed [NUM_W-1:0] wrap_sum;
    logic [PROD_W-1:0]       hue_num_next;
    logic [PROD_W-1:0]       s3_num_reg;
    logic [PROD_W-1:0]       s3_lowd_reg;
    logic [PROD_W-1:0]       s3_highd_reg;

    logic [CH_W-1:0] alpha_next;

    logic [CH_W-1:0] out_alpha;
    logic            out_grey;

    assign en4      = !m_tvalid || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HUE_LOW:  hue_low_reg  <= cfg_wdata;
                REG_HUE_HIGH: hue_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (en1) v1_reg   <= s_tvalid;
            if (en2) v2_reg   <= v1_reg;
            if (en3) v3_reg   <= v2_reg;
            if (en4) m_tvalid <= v3_reg;
        end
    end

    // Stage 1: sector and delta.
    hcka_sector u_sector (
        .red   (s_tdata[7:0]),
        .green (s_tdata[15:8]),
        .blue  (s_tdata[23:16]),
        .info  (sec_info)
    );

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_info_reg <= sec_info;
            s1_rgb_reg  <= s_tdata;
        end
    end

    // Stage 2: hue scaled by delta, before the wrap, and both bounds scaled by delta.
    assign d17      = {{(PROD_W-CH_W){1'b0}}, s1_info_reg.delta};
    assign diff_ext = {{(NUM_W-DIFF_W){s1_info_reg.diff[DIFF_W-1]}}, s1_info_reg.diff};
    assign diff60   = (diff_ext <<< 6) - (diff_ext <<< 2);

    always_comb begin
        unique case (s1_info_reg.sector)
            SEC_RED:   base_next = '0;
            SEC_GREEN: base_next = (d17 << 7) - (d17 << 3);
            SEC_BLUE:  base_next = (d17 << 8) - (d17 << 4);
            default:   base_next = '0;
        endcase
    end

    assign num_next   = $signed({2'b00, base_next}) + diff60;
    assign d360_next  = (d17 << 8) + (d17 << 6) + (d17 << 5) + (d17 << 3);
    assign lowd_next  = {{(PROD_W-HUE_W){1'b0}}, hue_low_reg} * d17;
    assign highd_next = {{(PROD_W-HUE_W){1'b0}}, hue_high_reg} * d17;

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_num_reg   <= num_next;
            s2_d360_reg  <= d360_next;
            s2_lowd_reg  <= lowd_next;
            s2_highd_reg <= highd_next;
            s2_rgb_reg   <= s1_rgb_reg;
        end
    end

    // Stage 3: a negative hue has a full turn added, which leaves it non-negative.
    assign wrap_sum     = s2_num_reg + $signed({2'b00, s2_d360_reg});
    assign hue_num_next = s2_num_reg[NUM_W-1] ? wrap_sum[PROD_W-1:0]
                                              : s2_num_reg[PROD_W-1:0];

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_num_reg   <= hue_num_next;
            s3_lowd_reg  <= s2_lowd_reg;
            s3_highd_reg <= s2_highd_reg;
            s3_rgb_reg   <= s2_rgb_reg;
        end
    end

    // Stage 4: strict range test, then the output register.
    assign alpha_next = (s3_num_reg > s3_lowd_reg && s3_num_reg < s3_highd_reg) ?
                        ALPHA_KEYED : ALPHA_OPAQUE;

    always_ff @(posedge aclk) begin
        if (en4) begin
            m_tdata <= {alpha_next, s3_rgb_reg};
        end
    end

    assign out_alpha = m_tdata[31:24];
    assign out_grey  = (m_tdata[7:0] == m_tdata[15:8]) && (m_tdata[15:8] == m_tdata[23:16]);

    `ASSERT_IMPL(a_full_when_blocked, !s_tready, v1_reg && v2_reg && v3_reg && m_tvalid)
    `ASSERT_NEXT(a_transfer_enters, s_tvalid && s_tready, v1_reg)
    `ASSERT_IMPL(a_alpha_code, m_tvalid, out_alpha == ALPHA_KEYED || out_alpha == ALPHA_OPAQUE)
    `ASSERT_IMPL(a_grey_opaque, m_tvalid && out_grey, out_alpha == ALPHA_OPAQUE)

endmodule

FILE: hdl/hcka_sector.sv
// Maximum, minimum, delta, sector and channel difference of one RGB pixel.
`timescale 1ns / 1ps

module hcka_sector (
    input  logic [hcka_pkg::CH_W-1:0] red,
    input  logic [hcka_pkg::CH_W-1:0] green,
    input  logic [hcka_pkg::CH_W-1:0] blue,
    output hcka_pkg::sector_info_t    info
);
    import hcka_pkg::*;

    logic [CH_W-1:0]          ch_max;
    logic [CH_W-1:0]          ch_min;
    logic signed [DIFF_W-1:0] r_s;
    logic signed [DIFF_W-1:0] g_s;
    logic signed [DIFF_W-1:0] b_s;

    assign r_s = $signed({1'b0, red});
    assign g_s = $signed({1'b0, green});
    assign b_s = $signed({1'b0, blue});

    always_comb begin
        ch_max = red;
        ch_min = red;
        if (green > ch_max) ch_max = green;
        if (blue > ch_max) ch_max = blue;
        if (green < ch_min) ch_min = green;
        if (blue < ch_min) ch_min = blue;

        info.delta = ch_max - ch_min;
        priority if (red >= green && red >= blue) begin
            info.sector = SEC_RED;
            info.diff   = g_s - b_s;
        end else if (green >= blue) begin
            info.sector = SEC_GREEN;
            info.diff   = b_s - r_s;
        end else begin
            info.sector = SEC_BLUE;
            info.diff   = r_s - g_s;
        end
    end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the hue chroma key unit: directed corners, then random pixels.
`timescale 1ns / 1ps

module testbench;

    import hcka_pkg::*;

    localparam int PHASES          = 8;
    localparam int PIXELS_PER_PHASE = 230;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_LIMIT     = 4000;

    // Keeps the key bounds, predicts each pixel's RGBA and checks it against the output.
    class key_scoreboard;
        typedef struct {
            logic [CH_W-1:0] red;
            logic [CH_W-1:0] green;
            logic [CH_W-1:0] blue;
            logic [CH_W-1:0] alpha;
        } rgba_t;

        rgba_t            expected_rgba[$];
        logic [HUE_W-1:0] hue_low  = HUE_LOW_RST;
        logic [HUE_W-1:0] hue_high = HUE_HIGH_RST;
        int               errors   = 0;
        int               accepted = 0;
        int               checked  = 0;
        int               keyed    = 0;

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void set_bounds(logic [HUE_W-1:0] lo, logic [HUE_W-1:0] hi);
            hue_low  = lo;
            hue_high = hi;
        endfunction

        // Hue times delta is an integer, so both bounds are tested exactly.
        function bit hue_inside_bounds(int r, int g, int b);
            int mx;
            int mn;
            int d;
            int num;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            if (mx == 0 || d == 0) return 1'b0;
            if (r == mx) num = 60 * (g - b);
            else if (g == mx) num = 120 * d + 60 * (b - r);
            else num = 240 * d + 60 * (r - g);
            if (num < 0) num += 360 * d;
            return (num > int'(hue_low) * d) && (num < int'(hue_high) * d);
        endfunction

        function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
            rgba_t item;
            item.red   = r;
            item.green = g;
            item.blue  = b;
            item.alpha = hue_inside_bounds(r, g, b) ? ALPHA_KEYED : ALPHA_OPAQUE;
            if (item.alpha == ALPHA_KEYED) keyed++;
            expected_rgba.push_back(item);
            accepted++;
        endfunction

        task check_result(logic [M_DATA_W-1:0] data);
            rgba_t want;
            if (expected_rgba.size() == 0) begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            want = expected_rgba.pop_front();
            checked++;
            if (data[7:0] !== want.red)
                report($sformatf("red %h, expected %h", data[7:0], want.red));
            if (data[15:8] !== want.green)
                report($sformatf("green %h, expected %h", data[15:8], want.green));
            if (data[23:16] !== want.blue)
                report($sformatf("blue %h, expected %h", data[23:16], want.blue));
            if (data[31:24] !== want.alpha)
                report($sformatf("alpha %h, expected %h for pixel %h%h%h (bounds %0d..%0d)",
                                 data[31:24], want.alpha, want.red, want.green, want.blue,
                                 hue_low, hue_high));
        endtask

        function int pending();
            return expected_rgba.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // red, green, blue
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // red, green, blue, alpha
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_HUE_LOW;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    key_scoreboard keys = new();

    bit send_idle     = 1'b1;
    bit recv_idle     = 1'b1;
    bit hold_off_req  = 1'b0;

    hue_chroma_key_alpha_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [23:0] pick_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         shape;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        shape = $urandom_range(0, 9);
        case (shape)
            0: begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                g = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            default: ;
        endcase
        return {b, g, r};
    endfunction

    // Called at a clock edge; returns at the edge where the transfer happens.
    task send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        keys.note_pixel(r, g, b);
    endtask

    task wait_for_drain();
        int waited;
        waited = 0;
        while (keys.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    task write_bounds(input logic [HUE_W-1:0] lo, input logic [HUE_W-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HUE_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_HUE_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        keys.set_bounds(lo, hi);
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                keys.check_result(m_tdata);
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [HUE_W-1:0] phase_low  [PHASES];
        logic [HUE_W-1:0] phase_high [PHASES];
        logic [23:0]      pix;
        phase_low  = '{HUE_LOW_RST,  9'd0,   9'd0,   9'd511, 9'd200, 9'd60,  9'd300, 9'd0};
        phase_high = '{HUE_HIGH_RST, 9'd360, 9'd511, 9'd0,   9'd200, 9'd180, 9'd511, 9'd0};
        phase_low[PHASES-1]  = HUE_W'($urandom_range(0, 360));
        phase_high[PHASES-1] = HUE_W'($urandom_range(0, 511));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corners under the reset bounds of 131 and 145.
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd254, 8'd1,   8'd128);
        send_pixel(8'd1,   8'd254, 8'd127);
        // Hues of exactly 131 and 145 sit on the bounds and stay opaque; 132 and 144 are keyed.
        send_pixel(8'd0,   8'd60,  8'd11);
        send_pixel(8'd0,   8'd60,  8'd25);
        send_pixel(8'd0,   8'd60,  8'd12);
        send_pixel(8'd0,   8'd60,  8'd24);
        send_pixel(8'd10,  8'd70,  8'd21);
        s_tvalid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            // The sender waits for every result before the bounds change.
            wait_for_drain();
            @(posedge aclk);
            if (phase > 0) write_bounds(phase_low[phase], phase_high[phase]);
            send_idle = (phase % 3 != 1) && (phase != 3);
            recv_idle = (phase % 4 != 1);
            // A long receiver hold-off against a sender that never pauses fills the pipeline.
            if (phase == 3) hold_off_req = 1'b1;
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                pix = pick_pixel();
                send_pixel(pix[7:0], pix[15:8], pix[23:16]);
            end
            s_tvalid <= 1'b0;
        end

        wait_for_drain();
        repeat (8) @(posedge aclk);
        while (keys.pending() > 0) begin
            keys.report("expected result never arrived");
            void'(keys.expected_rgba.pop_front());
        end

        $display("Run covered %0d pixels under %0d bound settings, %0d of them keyed.",
                 keys.accepted, PHASES, keys.keyed);
        $display("%0d results checked, %0d mismatches.", keys.checked, keys.errors);
        if (keys.errors == 0) begin
            $display("hue_chroma_key_alpha_unit regression: pass");
        end else begin
            $display("hue_chroma_key_alpha_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Timed out with %0d results outstanding.", keys.pending());
        $display("hue_chroma_key_alpha_unit regression: fail");
        $finish;
    end

endmodule

FILE: hue_chroma_key_alpha_unit.f
+incdir+hdl
hdl/hcka_pkg.sv
hdl/hcka_sector.sv
hdl/hue_chroma_key_alpha_unit.sv
bench/testbench.sv
